// ===== design/ssiq_pkg.sv =====
// Package for the stable sorted insert queue.
// Holds the request and status codes and the command bundle sent to the cells.
// No dependencies.
package ssiq_pkg;

    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        FN_PUSH_TAIL = 2'd0,
        FN_PUSH_KEY  = 2'd1,
        FN_POP       = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic pop;
        logic tail;
    } t_cell_cmd;

endpackage

// ===== design/ssiq_cell.sv =====
// One storage cell of the queue chain: holds one entry and one carry stage.
// A keyed insert walks down the chain through the carry stage of each cell.
// Depends on ssiq_pkg.
module ssiq_cell #(
    parameter int ID_BITS  = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ssiq_pkg::t_cell_cmd   i_cmd,
    input  logic [ID_BITS-1:0]    i_new_id,
    input  logic [KEY_BITS-1:0]   i_new_key,
    input  logic                  i_prev_valid,
    input  logic                  i_next_valid,
    input  logic [ID_BITS-1:0]    i_next_id,
    input  logic [KEY_BITS-1:0]   i_next_key,
    input  logic                  i_cin_valid,
    input  logic                  i_cin_disp,
    input  logic [ID_BITS-1:0]    i_cin_id,
    input  logic [KEY_BITS-1:0]   i_cin_key,
    output logic                  o_valid,
    output logic [ID_BITS-1:0]    o_id,
    output logic [KEY_BITS-1:0]   o_key,
    output logic                  o_cout_valid,
    output logic                  o_cout_disp,
    output logic [ID_BITS-1:0]    o_cout_id,
    output logic [KEY_BITS-1:0]   o_cout_key
);
    import ssiq_pkg::*;

    logic                r_valid, n_valid;
    logic [ID_BITS-1:0]  r_id, n_id;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic                r_cout_valid, n_cout_valid;
    logic                r_cout_disp, n_cout_disp;
    logic [ID_BITS-1:0]  r_cout_id, n_cout_id;
    logic [KEY_BITS-1:0] r_cout_key, n_cout_key;
    logic                take;

    assign take = i_cin_valid && (!r_valid || i_cin_disp || (i_cin_key < r_key));

    always_comb begin
        n_valid      = r_valid;
        n_id         = r_id;
        n_key        = r_key;
        n_cout_valid = 1'b0;
        n_cout_disp  = i_cin_disp;
        n_cout_id    = i_cin_id;
        n_cout_key   = i_cin_key;
        if (i_cmd.pop) begin
            n_valid = i_next_valid;
            n_id    = i_next_id;
            n_key   = i_next_key;
        end else if (i_cmd.tail) begin
            if (!r_valid && i_prev_valid) begin
                n_valid = 1'b1;
                n_id    = i_new_id;
                n_key   = i_new_key;
            end
        end else if (i_cin_valid) begin
            if (take) begin
                n_valid = 1'b1;
                n_id    = i_cin_id;
                n_key   = i_cin_key;
                if (r_valid) begin
                    n_cout_valid = 1'b1;
                    n_cout_disp  = 1'b1;
                    n_cout_id    = r_id;
                    n_cout_key   = r_key;
                end
            end else begin
                n_cout_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_cout_valid <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_cout_valid <= n_cout_valid;
        end
        r_id        <= n_id;
        r_key       <= n_key;
        r_cout_disp <= n_cout_disp;
        r_cout_id   <= n_cout_id;
        r_cout_key  <= n_cout_key;
    end

    assign o_valid      = r_valid;
    assign o_id         = r_id;
    assign o_key        = r_key;
    assign o_cout_valid = r_cout_valid;
    assign o_cout_disp  = r_cout_disp;
    assign o_cout_id    = r_cout_id;
    assign o_cout_key   = r_cout_key;

    a_no_carry_during_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pop || i_cmd.tail) |-> !i_cin_valid)
        else $error("carry in flight while a pop or tail push is applied");

endmodule

// ===== design/stable_sorted_insert_queue_unit.sv =====
// Stable sorted insert queue, top level: request decode, count and result register.
// The result of every accepted request is on the o_ result ports in the cycle after acceptance.
// Pops, tail pushes and rejected requests leave busy low, so one is taken per cycle.
// A keyed push keeps busy high while its carry moves down the cell chain, one cell per
// cycle, until it settles in the first empty cell. Synchronous reset empties the queue.
// The result strobe o_done lasts one cycle and cannot be stalled by the receiver.
module stable_sorted_insert_queue_unit #(
    parameter int DEPTH    = 16,
    parameter int ID_BITS  = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_func,
    input  logic [ID_BITS-1:0]            i_item_id,
    input  logic [KEY_BITS-1:0]           i_item_key,
    output logic                          o_done,
    output ssiq_pkg::t_status             o_status,
    output logic [ID_BITS-1:0]            o_popped_id,
    output logic [KEY_BITS-1:0]           o_popped_key,
    output logic [ssiq_pkg::COUNT_W-1:0]  o_entry_count,
    output logic                          o_head_valid,
    output logic [ID_BITS-1:0]            o_head_id
);
    import ssiq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DEPTH-1:0]    cell_valid;
    logic [ID_BITS-1:0]  cell_id [DEPTH];
    logic [KEY_BITS-1:0] cell_key [DEPTH];
    logic [DEPTH-1:0]    cout_valid;
    logic [DEPTH-1:0]    cout_disp;
    logic [ID_BITS-1:0]  cout_id [DEPTH];
    logic [KEY_BITS-1:0] cout_key [DEPTH];

    t_cell_cmd           cmd;
    logic                inj_valid;
    logic                acc;
    logic                full;
    logic                empty;

    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_done;
    t_status             r_status, n_status;
    logic [ID_BITS-1:0]  r_popped_id, n_popped_id;
    logic [KEY_BITS-1:0] r_popped_key, n_popped_key;
    logic                r_head_valid, n_head_valid;
    logic [ID_BITS-1:0]  r_head_id, n_head_id;
    logic [31:0]         count_ext;

    assign busy  = |cout_valid;
    assign acc   = start && !busy;
    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    always_comb begin
        n_status     = ST_OK;
        n_popped_id  = '0;
        n_popped_key = '0;
        n_count      = r_count;
        n_head_valid = cell_valid[0];
        n_head_id    = cell_valid[0] ? cell_id[0] : '0;
        cmd          = '0;
        inj_valid    = 1'b0;
        unique case (t_func'(i_func))
            FN_PUSH_TAIL: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    cmd.tail     = acc;
                    n_count      = r_count + CNT_W'(1);
                    n_head_valid = 1'b1;
                    n_head_id    = cell_valid[0] ? cell_id[0] : i_item_id;
                end
            end
            FN_PUSH_KEY: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    inj_valid    = acc;
                    n_count      = r_count + CNT_W'(1);
                    n_head_valid = 1'b1;
                    n_head_id    = (!cell_valid[0] || (i_item_key < cell_key[0]))
                                   ? i_item_id : cell_id[0];
                end
            end
            FN_POP: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    cmd.pop      = acc;
                    n_popped_id  = cell_id[0];
                    n_popped_key = cell_key[0];
                    n_count      = r_count - CNT_W'(1);
                    n_head_valid = cell_valid[1];
                    n_head_id    = cell_valid[1] ? cell_id[1] : '0;
                end
            end
            default: begin
            end
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                prev_valid;
        logic                next_valid;
        logic [ID_BITS-1:0]  next_id;
        logic [KEY_BITS-1:0] next_key;
        logic                cin_valid;
        logic                cin_disp;
        logic [ID_BITS-1:0]  cin_id;
        logic [KEY_BITS-1:0] cin_key;

        if (g == 0) begin : g_first
            assign prev_valid = 1'b1;
            assign cin_valid  = inj_valid;
            assign cin_disp   = 1'b0;
            assign cin_id     = i_item_id;
            assign cin_key    = i_item_key;
        end else begin : g_inner
            assign prev_valid = cell_valid[g-1];
            assign cin_valid  = cout_valid[g-1];
            assign cin_disp   = cout_disp[g-1];
            assign cin_id     = cout_id[g-1];
            assign cin_key    = cout_key[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_valid = 1'b0;
            assign next_id    = '0;
            assign next_key   = '0;
        end else begin : g_body
            assign next_valid = cell_valid[g+1];
            assign next_id    = cell_id[g+1];
            assign next_key   = cell_key[g+1];
        end

        ssiq_cell #(
            .ID_BITS  (ID_BITS),
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_new_id     (i_item_id),
            .i_new_key    (i_item_key),
            .i_prev_valid (prev_valid),
            .i_next_valid (next_valid),
            .i_next_id    (next_id),
            .i_next_key   (next_key),
            .i_cin_valid  (cin_valid),
            .i_cin_disp   (cin_disp),
            .i_cin_id     (cin_id),
            .i_cin_key    (cin_key),
            .o_valid      (cell_valid[g]),
            .o_id         (cell_id[g]),
            .o_key        (cell_key[g]),
            .o_cout_valid (cout_valid[g]),
            .o_cout_disp  (cout_disp[g]),
            .o_cout_id    (cout_id[g]),
            .o_cout_key   (cout_key[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= acc;
            if (acc) begin
                r_count <= n_count;
            end
        end
        if (acc) begin
            r_status     <= n_status;
            r_popped_id  <= n_popped_id;
            r_popped_key <= n_popped_key;
            r_head_valid <= n_head_valid;
            r_head_id    <= n_head_id;
        end
    end

    assign count_ext     = 32'(r_count);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_popped_id   = r_popped_id;
    assign o_popped_key  = r_popped_key;
    assign o_entry_count = count_ext[COUNT_W-1:0];
    assign o_head_valid  = r_head_valid;
    assign o_head_id     = r_head_id;

    a_done_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> o_done)
        else $error("accepted request produced no result beat");

    a_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> !o_done)
        else $error("result beat without an accepted request");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds queue depth");

    a_head_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_head_valid == (r_count != '0)))
        else $error("head valid disagrees with entry count");

    a_head_cell_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (cell_valid[0] == (r_count != '0)))
        else $error("head cell occupancy disagrees with entry count");

endmodule
